// ===== rtl/sdmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdmm_pkg;

   // default sizes of the stores
   localparam int MAX_ROWS_DEF     = 1024;
   localparam int MAX_FEATURES_DEF = 64;

   // request and response field widths
   localparam int OP_W    = 2;
   localparam int ROW_W   = 10;
   localparam int FEAT_W  = 6;
   localparam int VALUE_W = 16;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int DATA_W  = 40;

   // register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int ROWS_REG_W  = 11;
   localparam int FEAT_REG_W  = 7;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1024;
   localparam logic [FEAT_REG_W-1:0] FEAT_RESET = 7'd64;

   // row flags are kept as epoch tags; tag zero never matches
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 8'd0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

   // accumulator saturation bounds
   localparam logic signed [DATA_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [DATA_W-1:0] ACC_MIN = 40'sh80_0000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_EDGE  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } sdmm_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OUTPUT_ROWS = 2'd0,
      CSR_INPUT_ROWS  = 2'd1,
      CSR_FEATURES    = 2'd2
   } sdmm_csr_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load_input;
      logic row_lookup;
      logic mac_start;
      logic mac_issue;
      logic sweep_init;
      logic sweep_step;
      logic epoch_bump;
      logic load_rsp;
   } sdmm_cmd_type;

   // datapath to controller
   typedef struct packed {
      sdmm_op_type op;
      logic        in_range;
      logic        sweep_last;
      logic        epoch_last;
      logic        issue_done;
      logic        pipe_busy;
   } sdmm_stat_type;

endpackage

`default_nettype wire

// ===== rtl/sdmm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sdmm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [sdmm_pkg::OP_W-1:0]     op;
   logic        [sdmm_pkg::ROW_W-1:0]    target_row;
   logic        [sdmm_pkg::ROW_W-1:0]    source_row;
   logic        [sdmm_pkg::FEAT_W-1:0]   feature;
   logic signed [sdmm_pkg::VALUE_W-1:0]  value;

   modport source (output valid, op, target_row, source_row, feature, value, input ready);
   modport sink (input valid, op, target_row, source_row, feature, value, output ready);
endinterface

interface sdmm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic signed [sdmm_pkg::DATA_W-1:0]  data;

   modport source (output valid, status, data, input ready);
   modport sink (input valid, status, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sdmm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdmm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output sdmm_pkg::sdmm_cmd_type       cmd,
   input  wire sdmm_pkg::sdmm_stat_type stat
);

   typedef enum logic [2:0] {
      ST_SWEEP_RESET,
      ST_IDLE,
      ST_DECODE,
      ST_MAC_START,
      ST_MAC,
      ST_SWEEP_CLEAR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP_RESET: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.op)
               sdmm_pkg::OP_LOAD: begin
                  cmd.load_input = 1'b1;
                  state_in       = ST_FINISH;
               end
               sdmm_pkg::OP_EDGE: begin
                  if (stat.in_range) begin
                     cmd.row_lookup = 1'b1;
                     state_in       = ST_MAC_START;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               sdmm_pkg::OP_READ: begin
                  cmd.row_lookup = 1'b1;
                  state_in       = ST_FINISH;
               end
               sdmm_pkg::OP_CLEAR: begin
                  if (stat.epoch_last) begin
                     cmd.sweep_init = 1'b1;
                     state_in       = ST_SWEEP_CLEAR;
                  end else begin
                     cmd.epoch_bump = 1'b1;
                     state_in       = ST_FINISH;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_MAC_START: begin
            cmd.mac_start = 1'b1;
            state_in      = ST_MAC;
         end
         ST_MAC: begin
            if (!stat.issue_done) begin
               cmd.mac_issue = 1'b1;
            end else if (!stat.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_SWEEP_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sdmm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdmm_dp #(
   parameter int MAX_ROWS     = sdmm_pkg::MAX_ROWS_DEF,
   parameter int MAX_FEATURES = sdmm_pkg::MAX_FEATURES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire sdmm_pkg::sdmm_cmd_type                 cmd,
   output sdmm_pkg::sdmm_stat_type                     stat,
   input  wire logic        [sdmm_pkg::OP_W-1:0]       req_op,
   input  wire logic        [sdmm_pkg::ROW_W-1:0]      req_target_row,
   input  wire logic        [sdmm_pkg::ROW_W-1:0]      req_source_row,
   input  wire logic        [sdmm_pkg::FEAT_W-1:0]     req_feature,
   input  wire logic signed [sdmm_pkg::VALUE_W-1:0]    req_value,
   input  wire logic                                   csr_we,
   input  wire logic        [sdmm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [sdmm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                                        rsp_status,
   output logic signed      [sdmm_pkg::DATA_W-1:0]     rsp_data
);

   localparam int RW     = $clog2(MAX_ROWS);
   localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int AW     = RW + FW;
   localparam int RCW    = $clog2(MAX_ROWS + 1);
   localparam int RCMP_W = (RCW > sdmm_pkg::ROWS_REG_W) ? RCW : sdmm_pkg::ROWS_REG_W;
   localparam int FCW    = $clog2(MAX_FEATURES + 1);
   localparam int FCMP_W = (FCW > sdmm_pkg::FEAT_REG_W) ? FCW : sdmm_pkg::FEAT_REG_W;
   localparam int DW     = sdmm_pkg::DATA_W;
   localparam int PW     = sdmm_pkg::PROD_W;
   localparam int VW     = sdmm_pkg::VALUE_W;
   localparam int EW     = sdmm_pkg::EPOCH_W;

   // configuration registers
   logic [sdmm_pkg::ROWS_REG_W-1:0] output_rows_ff, input_rows_ff;
   logic [sdmm_pkg::FEAT_REG_W-1:0] features_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_rows_ff <= sdmm_pkg::ROWS_RESET;
         input_rows_ff  <= sdmm_pkg::ROWS_RESET;
         features_ff    <= sdmm_pkg::FEAT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sdmm_pkg::CSR_OUTPUT_ROWS: output_rows_ff <= csr_wdata;
            sdmm_pkg::CSR_INPUT_ROWS:  input_rows_ff  <= csr_wdata;
            sdmm_pkg::CSR_FEATURES:    features_ff    <= csr_wdata[sdmm_pkg::FEAT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // bounds, clamped to the store sizes
   logic [RCW-1:0] orows_eff, irows_eff;
   logic [FCW-1:0] nfeat_eff;

   assign orows_eff = (RCMP_W'(output_rows_ff) > RCMP_W'(MAX_ROWS)) ?
                      RCW'(MAX_ROWS) : RCW'(output_rows_ff);
   assign irows_eff = (RCMP_W'(input_rows_ff) > RCMP_W'(MAX_ROWS)) ?
                      RCW'(MAX_ROWS) : RCW'(input_rows_ff);
   assign nfeat_eff = (FCMP_W'(features_ff) > FCMP_W'(MAX_FEATURES)) ?
                      FCW'(MAX_FEATURES) : FCW'(features_ff);

   // latched request
   sdmm_pkg::sdmm_op_type            op_ff;
   logic [sdmm_pkg::ROW_W-1:0]       trow_ff, srow_ff;
   logic [sdmm_pkg::FEAT_W-1:0]      feat_ff;
   logic signed [VW-1:0]             value_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= sdmm_pkg::sdmm_op_type'(req_op);
         trow_ff  <= req_target_row;
         srow_ff  <= req_source_row;
         feat_ff  <= req_feature;
         value_ff <= req_value;
      end
   end

   logic trow_ok, srow_ok, feat_ok, in_range;

   assign trow_ok = RCMP_W'(trow_ff) < RCMP_W'(orows_eff);
   assign srow_ok = RCMP_W'(srow_ff) < RCMP_W'(irows_eff);
   assign feat_ok = FCMP_W'(feat_ff) < FCMP_W'(nfeat_eff);

   always_comb begin
      unique case (op_ff)
         sdmm_pkg::OP_LOAD:  in_range = srow_ok && feat_ok;
         sdmm_pkg::OP_EDGE:  in_range = trow_ok && srow_ok;
         sdmm_pkg::OP_READ:  in_range = trow_ok && feat_ok;
         sdmm_pkg::OP_CLEAR: in_range = 1'b1;
         default:            in_range = 1'b1;
      endcase
   end

   logic [RW-1:0] trow_idx, srow_idx;
   logic [FW-1:0] feat_idx;

   assign trow_idx = RW'(trow_ff);
   assign srow_idx = RW'(srow_ff);
   assign feat_idx = FW'(feat_ff);

   // epoch and tag sweep
   logic [EW-1:0] epoch_ff;
   logic [RW-1:0] sweep_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= sdmm_pkg::EPOCH_FIRST;
         sweep_cnt_ff <= '0;
      end else begin
         if (cmd.sweep_init) begin
            epoch_ff     <= sdmm_pkg::EPOCH_FIRST;
            sweep_cnt_ff <= '0;
         end else begin
            if (cmd.epoch_bump) begin
               epoch_ff <= epoch_ff + 1'b1;
            end
            if (cmd.sweep_step) begin
               sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
            end
         end
      end
   end

   logic [EW-1:0] tag_mem [0:(1 << RW)-1];
   logic [EW-1:0] tag_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         tag_mem[sweep_cnt_ff] <= sdmm_pkg::EPOCH_NONE;
      end else if (cmd.mac_start) begin
         tag_mem[trow_idx] <= epoch_ff;
      end
      if (cmd.row_lookup) begin
         tag_rd_ff <= tag_mem[trow_idx];
      end
   end

   // feature loop
   logic           fresh_ff;
   logic [FCW-1:0] n_ff, cnt_ff;
   logic [FW-1:0]  cnt_idx;

   assign cnt_idx = FW'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         n_ff     <= '0;
         fresh_ff <= 1'b0;
      end else if (cmd.mac_start) begin
         cnt_ff   <= '0;
         fresh_ff <= (tag_rd_ff != epoch_ff);
         n_ff     <= (tag_rd_ff != epoch_ff) ? FCW'(MAX_FEATURES) : nfeat_eff;
      end else if (cmd.mac_issue) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // dense input store
   logic signed [VW-1:0] in_mem [0:(1 << AW)-1];
   logic signed [VW-1:0] in_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_input && in_range) begin
         in_mem[{srow_idx, feat_idx}] <= value_ff;
      end
      if (cmd.mac_issue) begin
         in_rd_ff <= in_mem[{srow_idx, cnt_idx}];
      end
   end

   // accumulator store, one read and one write port
   logic signed [DW-1:0] acc_mem [0:(1 << AW)-1];
   logic signed [DW-1:0] acc_rd_ff;
   logic [AW-1:0]        acc_rd_addr;
   logic                 s1_valid_ff, s1_active_ff, s2_valid_ff;
   logic [FW-1:0]        s1_feat_ff, s2_feat_ff;
   logic signed [PW-1:0] prod, prod_ff;
   logic signed [DW-1:0] acc_old_ff, acc_sat;
   logic signed [DW:0]   acc_sum;

   assign acc_rd_addr = cmd.row_lookup ? {trow_idx, feat_idx} : {trow_idx, cnt_idx};

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_mem[{trow_idx, s2_feat_ff}] <= acc_sat;
      end
      if (cmd.row_lookup || cmd.mac_issue) begin
         acc_rd_ff <= acc_mem[acc_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.mac_issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign prod = value_ff * in_rd_ff;

   always_ff @(posedge clock) begin
      s1_feat_ff   <= cnt_idx;
      s1_active_ff <= (cnt_ff < nfeat_eff);
      s2_feat_ff   <= s1_feat_ff;
      prod_ff      <= s1_active_ff ? prod : '0;
      acc_old_ff   <= fresh_ff ? '0 : acc_rd_ff;
   end

   assign acc_sum = {acc_old_ff[DW-1], acc_old_ff} + {{(DW + 1 - PW){prod_ff[PW-1]}}, prod_ff};

   always_comb begin
      if (acc_sum[DW] != acc_sum[DW-1]) begin
         acc_sat = acc_sum[DW] ? sdmm_pkg::ACC_MIN : sdmm_pkg::ACC_MAX;
      end else begin
         acc_sat = acc_sum[DW-1:0];
      end
   end

   // response register
   logic                 rsp_status_ff;
   logic signed [DW-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= !in_range;
         rsp_data_ff   <= (op_ff == sdmm_pkg::OP_READ && in_range && tag_rd_ff == epoch_ff) ?
                          acc_rd_ff : '0;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

   assign stat.op         = op_ff;
   assign stat.in_range   = in_range;
   assign stat.sweep_last = (sweep_cnt_ff == {RW{1'b1}});
   assign stat.epoch_last = (epoch_ff == {EW{1'b1}});
   assign stat.issue_done = (cnt_ff == n_ff);
   assign stat.pipe_busy  = s1_valid_ff || s2_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/sparse_dense_matmul_edge_list.sv =====
`timescale 1ns / 1ps
`default_nettype none

// sparse (coo edge list) times dense matrix product, fixed point
// req_chan carries one request: op, target_row, source_row, feature, value
//   load writes one q8.8 input element, edge adds weight times the source row
//   into the target row for every feature in use, read returns one q24.16
//   accumulator, clear drops all row flags
// rsp_chan returns one response per request: status (1 = index out of range,
//   request ignored) and data (read result, zero otherwise)
// csr_we / csr_index / csr_wdata write output_rows, input_rows, features_in_use
// one request at a time: req_chan.ready is high only while the block is free
// load, read, out-of-range edge and most clears go from decode straight to the response
//   register; an in-range edge issues features_in_use multiply-accumulates, or max_features
//   on the first edge into a row since the last clear, one per cycle through the
//   accumulator memory ports, and answers once the mac pipeline has drained
// every 255th clear re-sweeps all 2^clog2(max_rows) entries of the row tag memory
// after reset the same tag sweep runs with req_chan.ready low; csr writes are
//   taken during it
// a stalled response sits in an output register; the next request is still
//   accepted and the block waits only when its own response is due

module sparse_dense_matmul_edge_list #(
   parameter int MAX_ROWS     = sdmm_pkg::MAX_ROWS_DEF,
   parameter int MAX_FEATURES = sdmm_pkg::MAX_FEATURES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   sdmm_req_if.sink                                  req_chan,
   sdmm_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [sdmm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sdmm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   sdmm_pkg::sdmm_cmd_type  cmd;
   sdmm_pkg::sdmm_stat_type stat;

   // sequencer: owns request handshake and response valid
   sdmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // stores, mac pipeline, range checks and response payload
   sdmm_dp #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_FEATURES (MAX_FEATURES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_chan.op),
      .req_target_row (req_chan.target_row),
      .req_source_row (req_chan.source_row),
      .req_feature    (req_chan.feature),
      .req_value      (req_chan.value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_chan.status),
      .rsp_data       (rsp_chan.data)
   );

   // response register is only overwritten once it is empty or being taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response overwritten while stalled");

   // one request in flight: an accept closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   // tag sweep never overlaps the edge loop
   a_sweep_vs_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (!cmd.mac_issue && !cmd.mac_start && !stat.pipe_busy))
      else $error("tag sweep during edge update");

endmodule

`default_nettype wire
